// ===== rtl/assert_macros.svh =====
// Assertion macros used by the decoder top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante implies cons next cycle");

`endif

// ===== rtl/rccd_pkg.sv =====
// Package for the RC command decoder: codes, item types, character classes.
// No dependencies.
package rccd_pkg;

  localparam int unsigned MaxDigitsDefault = 7;

  localparam logic [7:0]  SpeedMinReset     = 8'd60;
  localparam logic [7:0]  SpeedMaxReset     = 8'd255;
  localparam logic [15:0] TimeoutTicksReset = 16'd500;
  localparam logic [7:0]  DefaultSpeedReset = 8'd200;

  localparam logic [7:0] CharHash = 8'h23;
  localparam logic [7:0] CharLf   = 8'h0A;
  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [8:0]  AccSat    = 9'd256;
  localparam logic [15:0] IdleSat   = 16'hFFFF;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSpeedMin     = 2'd0,
    CfgSpeedMax     = 2'd1,
    CfgTimeoutTicks = 2'd2,
    CfgDefaultSpeed = 2'd3
  } cfg_idx_e;

  typedef enum logic [0:0] {
    ModeByte = 1'b0,
    ModeTick = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    MotionStop     = 4'd0,
    MotionFwd      = 4'd1,
    MotionRev      = 4'd2,
    MotionLeft     = 4'd3,
    MotionRight    = 4'd4,
    MotionFwdLeft  = 4'd5,
    MotionFwdRight = 4'd6,
    MotionRevLeft  = 4'd7,
    MotionRevRight = 4'd8
  } motion_e;

  typedef struct packed {
    logic       is_hash;
    logic       is_eol;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_motion;
    motion_e    motion;
  } char_class_t;

endpackage

// ===== rtl/rccd_in_if.sv =====
// Input channel: command bytes and millisecond ticks.
// Depends on nothing.
interface rccd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

// ===== rtl/rccd_out_if.sv =====
// Output channel: motion commands with speed and failsafe flag.
// Depends on nothing.
interface rccd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] motion;
  logic [7:0] drive_speed;
  logic       by_failsafe;

  modport source (output valid, output motion, output drive_speed, output by_failsafe,
                  input ready);
  modport sink   (input valid, input motion, input drive_speed, input by_failsafe,
                  output ready);
endinterface

// ===== rtl/rccd_char_decode.sv =====
// Classifies one received character: hash, line end, digit, motion letter.
// Depends on rccd_pkg.
module rccd_char_decode
  import rccd_pkg::*;
(
  input  logic [7:0]  byte_i,
  output char_class_t cls_o
);

  always_comb begin
    cls_o.is_hash   = (byte_i == CharHash);
    cls_o.is_eol    = (byte_i == CharLf) || (byte_i == CharCr);
    cls_o.is_digit  = (byte_i >= CharZero) && (byte_i <= CharNine);
    cls_o.digit     = byte_i[3:0];
    cls_o.is_motion = 1'b1;
    cls_o.motion    = MotionStop;
    case (byte_i)
      "F", "f": cls_o.motion = MotionFwd;
      "B", "b": cls_o.motion = MotionRev;
      "L", "l": cls_o.motion = MotionLeft;
      "R", "r": cls_o.motion = MotionRight;
      "G", "g": cls_o.motion = MotionFwdLeft;
      "I", "i": cls_o.motion = MotionFwdRight;
      "H", "h": cls_o.motion = MotionRevLeft;
      "J", "j": cls_o.motion = MotionRevRight;
      "S", "s", "Q", "q": cls_o.motion = MotionStop;
      default: cls_o.is_motion = 1'b0;
    endcase
  end

endmodule

// ===== rtl/rc_command_decoder_with_failsafe.sv =====
// Top level of the RC command decoder with idle failsafe.
// Depends on rccd_pkg, rccd_in_if, rccd_out_if, rccd_char_decode, assert_macros.svh.
//
// Usage:
//   in_i carries one transaction per received byte (mode 0) or per
//   millisecond tick (mode 1). out_o carries motion transactions: a motion
//   letter outside a speed command gives one, and an idle timeout gives one
//   stop with by_failsafe set. Other items give none.
//   "#digits" followed by CR or LF sets the drive speed if it lies within
//   the configured low and high speed limits. cfg_we_i writes register cfg_idx_i.
//   Output: a result is registered and is on out_o in the cycle after its input transaction.
//   Throughput: one input transaction per cycle while in_i.ready is high;
//   the state update and the result are formed in the same cycle, bounded
//   by the times-ten-plus-digit add and the idle counter compare.
//   Stall: the result register holds while out_o.ready is low; in_i.ready
//   drops only while a held result is not taken in the same cycle.
//   Reset: registers return to their reset values, parsing state clears,
//   idle time is zero and current speed is 200.
module rc_command_decoder_with_failsafe
  import rccd_pkg::*;
#(
  parameter int unsigned MaxDigits = MaxDigitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rccd_in_if.sink             in_i,
  rccd_out_if.source          out_o
);
  `include "assert_macros.svh"

  localparam int unsigned DigW = $clog2(MaxDigits + 1);

  logic [7:0]  spd_lo_q, spd_hi_q;
  logic [15:0] timeout_q;

  logic            in_cmd_q, in_cmd_d;
  logic [DigW-1:0] dig_cnt_q, dig_cnt_d;
  logic [8:0]      acc_q, acc_d;
  logic [7:0]      speed_q, speed_d;
  logic [15:0]     idle_q, idle_d;
  logic            fs_done_q, fs_done_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  motion_q, motion_d;
  logic [7:0]  drv_q, drv_d;
  logic        by_fs_q, by_fs_d;
  logic        emit;

  logic        in_acc;
  char_class_t cls;
  logic [11:0] prod;
  logic [15:0] idle_inc;

  rccd_char_decode u_char_decode (
    .byte_i (in_i.byte_value),
    .cls_o  (cls)
  );

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_lo_q  <= SpeedMinReset;
      spd_hi_q  <= SpeedMaxReset;
      timeout_q <= TimeoutTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSpeedMin:     spd_lo_q  <= cfg_data_i[7:0];
        CfgSpeedMax:     spd_hi_q  <= cfg_data_i[7:0];
        CfgTimeoutTicks: timeout_q <= cfg_data_i;
        // default_speed writes are ignored; the speed at reset is the fixed DefaultSpeedReset
        CfgDefaultSpeed: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign prod     = ({3'b000, acc_q} * 12'd10) + {8'h00, cls.digit};
  assign idle_inc = (idle_q == IdleSat) ? idle_q : idle_q + 16'd1;

  always_comb begin
    in_cmd_d  = in_cmd_q;
    dig_cnt_d = dig_cnt_q;
    acc_d     = acc_q;
    speed_d   = speed_q;
    idle_d    = idle_q;
    fs_done_d = fs_done_q;
    emit      = 1'b0;
    motion_d  = MotionStop;
    drv_d     = 8'h00;
    by_fs_d   = 1'b0;
    if (in_acc) begin
      if (in_i.mode == ModeTick) begin
        idle_d = idle_inc;
        if ((idle_inc > timeout_q) && !fs_done_q) begin
          fs_done_d = 1'b1;
          emit      = 1'b1;
          by_fs_d   = 1'b1;
        end
      end else begin
        idle_d    = 16'h0000;
        fs_done_d = 1'b0;
        if (cls.is_hash) begin
          in_cmd_d  = 1'b1;
          dig_cnt_d = '0;
          acc_d     = 9'd0;
        end else if (in_cmd_q) begin
          if (cls.is_eol) begin
            in_cmd_d = 1'b0;
            if ((dig_cnt_q != '0) && (acc_q >= {1'b0, spd_lo_q})
                && (acc_q <= {1'b0, spd_hi_q})) begin
              speed_d = acc_q[7:0];
            end
          end else if (cls.is_digit && (dig_cnt_q < DigW'(MaxDigits))) begin
            acc_d     = (prod > {3'b000, AccSat}) ? AccSat : prod[8:0];
            dig_cnt_d = dig_cnt_q + DigW'(1);
          end
        end else if (cls.is_motion) begin
          emit     = 1'b1;
          motion_d = cls.motion;
          drv_d    = (cls.motion == MotionStop) ? 8'h00 : speed_q;
        end
      end
    end
    out_valid_d = (out_valid_q && !out_o.ready) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cmd_q    <= 1'b0;
      dig_cnt_q   <= '0;
      acc_q       <= 9'd0;
      speed_q     <= DefaultSpeedReset;
      idle_q      <= 16'h0000;
      fs_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_cmd_q    <= in_cmd_d;
      dig_cnt_q   <= dig_cnt_d;
      acc_q       <= acc_d;
      speed_q     <= speed_d;
      idle_q      <= idle_d;
      fs_done_q   <= fs_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      motion_q <= motion_d;
      drv_q    <= drv_d;
      by_fs_q  <= by_fs_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.motion      = motion_q;
  assign out_o.drive_speed = drv_q;
  assign out_o.by_failsafe = by_fs_q;

  `ASSERT_IMPLY(a_fs_is_stop, clk_i, rst_ni, out_valid_q && by_fs_q,
                motion_q == MotionStop && drv_q == 8'h00)
  `ASSERT_NEXT(a_byte_clears_idle, clk_i, rst_ni, in_acc && in_i.mode == ModeByte,
               idle_q == 16'h0000 && !fs_done_q)
  `ASSERT_IMPLY(a_digits_bounded, clk_i, rst_ni, 1'b1, dig_cnt_q <= DigW'(MaxDigits))
  `ASSERT_IMPLY(a_acc_saturates, clk_i, rst_ni, 1'b1, acc_q <= AccSat)
  `ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, emit, out_valid_q)

endmodule
